// File: rtl/sliding_window_anagram_finder_macros.svh
// assertion helpers used by rtl/sliding_window_anagram_finder.sv
`ifndef SLIDING_WINDOW_ANAGRAM_FINDER_MACROS_SVH
`define SLIDING_WINDOW_ANAGRAM_FINDER_MACROS_SVH

// same-cycle implication, disabled in reset
`define SWAF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define SWAF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/swaf_pkg.sv
package swaf_pkg;

  // parameter defaults
  localparam int MAX_WORD_DEF   = 256;
  localparam int COUNT_BITS_DEF = 32;

  // fixed field widths
  localparam int KIND_W  = 2;
  localparam int SYM_W   = 8;
  localparam int SYMBOLS = 1 << SYM_W;
  localparam int MISM_W  = $clog2(SYMBOLS + 1);
  localparam int POS_W   = 32;
  localparam int FOUND_W = 32;

  // item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR   = 2'd0,
    KIND_PATTERN = 2'd1,
    KIND_TEXT    = 2'd2
  } kind_t;

  // status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

endpackage

// File: rtl/swaf_if.sv
// input item channel
interface swaf_in_if;
  logic                             valid;
  logic                             ready;
  logic [swaf_pkg::KIND_W-1:0]      kind;
  logic [swaf_pkg::SYM_W-1:0]       symbol;

  modport source (output valid, output kind, output symbol, input ready);
  modport sink   (input valid, input kind, input symbol, output ready);
endinterface

// result item channel
interface swaf_out_if;
  logic                             valid;
  logic                             ready;
  logic                             match;
  logic [swaf_pkg::POS_W-1:0]       start_position;
  logic [swaf_pkg::FOUND_W-1:0]     found_count;
  logic                             status;

  modport source (output valid, output match, output start_position,
                  output found_count, output status, input ready);
  modport sink   (input valid, input match, input start_position,
                  input found_count, input status, output ready);
endinterface

// File: rtl/sliding_window_anagram_finder.sv
// Streaming anagram search: a clear item starts a new search, pattern items load the
// pattern (up to MAX_WORD bytes, refused with status 1 when too long or after text), and
// every text item returns whether the window ending at it is a permutation of the pattern,
// the window start index and the saturating match total; every item gives one result.
// Clear, pattern and unused items are taken one per cycle unless the output stalls; a text
// item holds off the next item for its second count write to the per-byte count store,
// which has one write port. Each result is registered as its item leaves the work stage,
// and the output register lets the next item enter while a result waits. A clear item
// clears the count store at once via per-entry valid flags; no clearing pass after reset.
`include "sliding_window_anagram_finder_macros.svh"

module sliding_window_anagram_finder #(
  parameter int MAX_WORD   = swaf_pkg::MAX_WORD_DEF,
  parameter int COUNT_BITS = swaf_pkg::COUNT_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  swaf_in_if.sink         in_chan,
  swaf_out_if.source      out_chan
);

  localparam int PLEN_W = $clog2(MAX_WORD + 1);
  localparam int PTR_W  = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
  localparam int CNT_W  = $clog2(MAX_WORD + 1) + 1;
  localparam int TOT_W  = (COUNT_BITS < 32) ? COUNT_BITS : 32;
  localparam int SYM_W  = swaf_pkg::SYM_W;
  localparam int MISM_W = swaf_pkg::MISM_W;
  localparam int POS_W  = swaf_pkg::POS_W;
  localparam int FND_W  = swaf_pkg::FOUND_W;

  // search state
  logic [PLEN_W-1:0]  plen_r, plen_nxt;
  logic [PLEN_W-1:0]  fill_r, fill_nxt;
  logic [PTR_W-1:0]   ptr_r, ptr_nxt;
  logic [POS_W-1:0]   tidx_r, tidx_nxt;
  logic [TOT_W-1:0]   tot_r, tot_nxt;
  logic [MISM_W-1:0]  mism_r, mism_nxt;
  logic               started_r, started_nxt;

  // count store and its valid flags
  logic [CNT_W-1:0]   cnt_mem [swaf_pkg::SYMBOLS];
  logic [swaf_pkg::SYMBOLS-1:0] cnt_vld_r, cnt_vld_nxt;
  logic [CNT_W-1:0]   mem_a_r, mem_b_r;
  logic               vld_a_r, vld_b_r;
  logic               fwd_a_r, fwd_b_r;
  logic [CNT_W-1:0]   fwd_wd_r;
  logic               cnt_we;
  logic [SYM_W-1:0]   cnt_wa;
  logic [CNT_W-1:0]   cnt_wd;

  // window ring
  logic [SYM_W-1:0]   win_mem [MAX_WORD];
  logic [SYM_W-1:0]   win_mem_r, win_fwd_d_r, win_rd;
  logic               win_fwd_r, win_we;

  // work stage and pending leave update
  logic               s1_vld_r, s1_vld_nxt;
  swaf_pkg::kind_t    s1_kind_r;
  logic [SYM_W-1:0]   s1_sym_r, s1_leave_r;
  logic               s2_vld_r, s2_vld_nxt;
  logic [SYM_W-1:0]   s2_addr_r;
  logic [CNT_W-1:0]   s2_wd_r;

  // output register
  logic               out_vld_r, out_vld_nxt;
  logic               out_match_r, out_status_r;
  logic [POS_W-1:0]   out_start_r;
  logic [FND_W-1:0]   out_found_r;

  // handshake
  logic               in_acc, in_rdy, clr_acc, s1_adv;

  // work stage results
  logic [CNT_W-1:0]   a_val, b_val, new_a, new_b;
  logic               dec_leave, same_sym, refused, hit;
  logic [PLEN_W-1:0]  ptr_inc;
  logic               cnt_wr_s1, leave_wr, win_wr;
  logic [MISM_W-1:0]  mism_upd;
  logic [PLEN_W-1:0]  plen_upd, fill_upd;
  logic [PTR_W-1:0]   ptr_upd;
  logic [POS_W-1:0]   tidx_upd, res_start;
  logic [TOT_W-1:0]   tot_upd;
  logic               started_upd, res_match, res_status;
  logic [FND_W-1:0]   res_found;

  // a text item in the work stage holds off the next item for its second count write
  assign s1_adv  = s1_vld_r && (!out_vld_r || out_chan.ready);
  assign in_rdy  = !s1_vld_r || (s1_adv && (s1_kind_r != swaf_pkg::KIND_TEXT));
  assign in_acc  = in_chan.valid && in_rdy;
  assign clr_acc = in_acc && (in_chan.kind == swaf_pkg::KIND_CLEAR);
  assign in_chan.ready = in_rdy;

  // window byte at the ring pointer, with write forwarding
  assign win_rd = win_fwd_r ? win_fwd_d_r : win_mem_r;

  // count store: one write port, two reads taken when an item is accepted
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (in_acc) begin
      mem_a_r <= cnt_mem[in_chan.symbol];
      mem_b_r <= cnt_mem[win_rd];
    end
  end

  // read side flags and forwarding of the write on the same edge
  always_ff @(posedge clk) begin
    if (in_acc) begin
      vld_a_r  <= cnt_vld_r[in_chan.symbol];
      vld_b_r  <= cnt_vld_r[win_rd];
      fwd_a_r  <= cnt_we && (cnt_wa == in_chan.symbol);
      fwd_b_r  <= cnt_we && (cnt_wa == win_rd);
      fwd_wd_r <= cnt_wd;
    end
  end

  // window ring: read always follows the next pointer
  always_ff @(posedge clk) begin
    if (win_we) begin
      win_mem[ptr_r] <= s1_sym_r;
    end
    win_mem_r   <= win_mem[ptr_nxt];
    win_fwd_r   <= win_we && (ptr_r == ptr_nxt);
    win_fwd_d_r <= s1_sym_r;
  end

  // work stage: count updates, mismatch tracking and the result
  always_comb begin
    a_val       = fwd_a_r ? fwd_wd_r : (vld_a_r ? mem_a_r : '0);
    b_val       = fwd_b_r ? fwd_wd_r : (vld_b_r ? mem_b_r : '0);
    dec_leave   = (fill_r >= plen_r);
    same_sym    = dec_leave && (s1_sym_r == s1_leave_r);
    refused     = started_r || (plen_r >= PLEN_W'(MAX_WORD));
    ptr_inc     = PLEN_W'(ptr_r) + PLEN_W'(1);
    new_a       = a_val;
    new_b       = b_val - CNT_W'(1);
    cnt_wr_s1   = 1'b0;
    leave_wr    = 1'b0;
    win_wr      = 1'b0;
    hit         = 1'b0;
    mism_upd    = mism_r;
    plen_upd    = plen_r;
    fill_upd    = fill_r;
    ptr_upd     = ptr_r;
    tidx_upd    = tidx_r;
    tot_upd     = tot_r;
    started_upd = started_r;
    res_match   = 1'b0;
    res_start   = '0;
    res_status  = swaf_pkg::STATUS_OK;
    res_found   = FND_W'(tot_r);
    unique case (s1_kind_r)
      swaf_pkg::KIND_CLEAR: begin
        res_found = '0;
      end
      swaf_pkg::KIND_PATTERN: begin
        if (refused) begin
          res_status = swaf_pkg::STATUS_REFUSED;
        end else begin
          new_a     = a_val - CNT_W'(1);
          cnt_wr_s1 = 1'b1;
          plen_upd  = plen_r + PLEN_W'(1);
          mism_upd  = mism_r + MISM_W'((a_val == '0) && (new_a != '0))
                             - MISM_W'((a_val != '0) && (new_a == '0));
        end
      end
      swaf_pkg::KIND_TEXT: begin
        started_upd = 1'b1;
        tidx_upd    = tidx_r + POS_W'(1);
        if (plen_r == '0) begin
          hit = (mism_r == '0);
        end else begin
          // same byte entering and leaving leaves its count unchanged
          new_a     = same_sym ? a_val : a_val + CNT_W'(1);
          cnt_wr_s1 = 1'b1;
          win_wr    = 1'b1;
          leave_wr  = dec_leave && !same_sym;
          fill_upd  = dec_leave ? fill_r : fill_r + PLEN_W'(1);
          ptr_upd   = (ptr_inc >= plen_r) ? '0 : PTR_W'(ptr_inc);
          mism_upd  = mism_r + MISM_W'((a_val == '0) && (new_a != '0))
                             - MISM_W'((a_val != '0) && (new_a == '0))
                             + MISM_W'(leave_wr && (b_val == '0))
                             - MISM_W'(leave_wr && (new_b == '0));
          hit       = (mism_upd == '0);
        end
        if (hit) begin
          res_match = 1'b1;
          res_start = tidx_r - POS_W'(plen_r) + POS_W'(1);
          tot_upd   = (tot_r != '1) ? tot_r + TOT_W'(1) : tot_r;
        end
        res_found = FND_W'(tot_upd);
      end
      default: begin
        res_found = FND_W'(tot_r);
      end
    endcase
  end

  // count store write port: the pending leave update goes first
  assign cnt_we = (s2_vld_r || (s1_adv && cnt_wr_s1)) && !clr_acc;
  assign cnt_wa = s2_vld_r ? s2_addr_r : s1_sym_r;
  assign cnt_wd = s2_vld_r ? s2_wd_r : new_a;
  assign win_we = s1_adv && win_wr;

  // next state: a clear takes effect at its accept edge
  always_comb begin
    plen_nxt    = plen_r;
    fill_nxt    = fill_r;
    ptr_nxt     = ptr_r;
    tidx_nxt    = tidx_r;
    tot_nxt     = tot_r;
    mism_nxt    = mism_r;
    started_nxt = started_r;
    cnt_vld_nxt = cnt_vld_r;
    if (clr_acc) begin
      plen_nxt    = '0;
      fill_nxt    = '0;
      ptr_nxt     = '0;
      tidx_nxt    = '0;
      tot_nxt     = '0;
      mism_nxt    = '0;
      started_nxt = 1'b0;
      cnt_vld_nxt = '0;
    end else begin
      if (s1_adv) begin
        plen_nxt    = plen_upd;
        fill_nxt    = fill_upd;
        ptr_nxt     = ptr_upd;
        tidx_nxt    = tidx_upd;
        tot_nxt     = tot_upd;
        mism_nxt    = mism_upd;
        started_nxt = started_upd;
      end
      if (cnt_we) begin
        cnt_vld_nxt[cnt_wa] = 1'b1;
      end
    end
  end

  // stage occupancy
  always_comb begin
    s1_vld_nxt  = s1_vld_r;
    if (in_acc) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_vld_nxt = 1'b0;
    end
    s2_vld_nxt  = s1_adv && leave_wr;
    out_vld_nxt = out_vld_r;
    if (s1_adv) begin
      out_vld_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r    <= '0;
      fill_r    <= '0;
      ptr_r     <= '0;
      tidx_r    <= '0;
      tot_r     <= '0;
      mism_r    <= '0;
      started_r <= 1'b0;
      cnt_vld_r <= '0;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      plen_r    <= plen_nxt;
      fill_r    <= fill_nxt;
      ptr_r     <= ptr_nxt;
      tidx_r    <= tidx_nxt;
      tot_r     <= tot_nxt;
      mism_r    <= mism_nxt;
      started_r <= started_nxt;
      cnt_vld_r <= cnt_vld_nxt;
      s1_vld_r  <= s1_vld_nxt;
      s2_vld_r  <= s2_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // item payload, leave update and result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r  <= swaf_pkg::kind_t'(in_chan.kind);
      s1_sym_r   <= in_chan.symbol;
      s1_leave_r <= win_rd;
    end
    if (s1_adv) begin
      s2_addr_r    <= s1_leave_r;
      s2_wd_r      <= new_b;
      out_match_r  <= res_match;
      out_start_r  <= res_start;
      out_found_r  <= res_found;
      out_status_r <= res_status;
    end
  end

  assign out_chan.valid          = out_vld_r;
  assign out_chan.match          = out_match_r;
  assign out_chan.start_position = out_start_r;
  assign out_chan.found_count    = out_found_r;
  assign out_chan.status         = out_status_r;

  // checks
  `SWAF_ASSERT_IMP(a_leave_alone, clk, rst_n, s2_vld_r, !s1_vld_r, "leave update overlaps a busy stage")
  `SWAF_ASSERT_IMP(a_text_holds, clk, rst_n, s1_vld_r && (s1_kind_r == swaf_pkg::KIND_TEXT), !in_rdy, "item taken during text update")
  `SWAF_ASSERT_NXT(a_clear_state, clk, rst_n, clr_acc, (mism_r == '0) && (plen_r == '0) && (tidx_r == '0) && !started_r, "clear left state behind")
  `SWAF_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, fill_r <= plen_r, "window fill above pattern length")

endmodule
